// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/fqau_pkg.sv -----
`default_nettype none

package fqau_pkg;

    localparam int DATA_W    = 32;
    localparam int HALF_W    = DATA_W / 2;
    localparam int CFG_W     = 31;
    localparam int FRAC_BITS = 27;

    localparam logic [DATA_W-1:0] ONE_Q        = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] HALF_Q       = DATA_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] THREE_HALF_Q = DATA_W'(3) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] RND_LO       = DATA_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] RND_MID      = DATA_W'(16);
    localparam int SHIFT_MID = FRAC_BITS - HALF_W;
    localparam int SHIFT_HI  = DATA_W - FRAC_BITS;

    localparam logic [CFG_W-1:0] ROT_COS_RESET = CFG_W'(134217593);
    localparam logic [CFG_W-1:0] ROT_SIN_RESET = CFG_W'(117037);

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ROT_COS = 1'b0;
    localparam cfg_idx_t CFG_ROT_SIN = 1'b1;

    localparam int PROG_LEN = 39;
    localparam int PC_W     = $clog2(PROG_LEN);
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [4:0] {
        SRC_B0, SRC_B1, SRC_B2, SRC_B3,
        SRC_KX, SRC_KY, SRC_KZ,
        SRC_D0, SRC_D1, SRC_D2, SRC_D3,
        SRC_P1, SRC_P2, SRC_NORM, SRC_HALF, SRC_COS, SRC_SIN
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_NORM,
        DST_D0, DST_D1, DST_D2, DST_D3,
        DST_P0, DST_P1, DST_P2, DST_P3,
        DST_B1, DST_B2
    } dst_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB, ACC_RSUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_WAIT, SEQ_COMMIT
    } seq_t;

    typedef struct packed {
        logic    issue;
        src_t    src_a;
        src_t    src_b;
        acc_op_t acc;
        dst_t    dst;
        seq_t    seq;
    } ucode_t;

    localparam ucode_t UC_NOP = '{1'b0, SRC_B0, SRC_B0, ACC_LOAD, DST_NONE, SEQ_NEXT};

    function automatic ucode_t uop(input src_t a, input src_t b, input acc_op_t acc,
                                   input dst_t dst);
        ucode_t u;
        u = '{1'b1, a, b, acc, dst, SEQ_NEXT};
        return u;
    endfunction

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t u;
        u = UC_NOP;
        case (pc)
            6'd0:  u = '{1'b0, SRC_B0, SRC_B0, ACC_LOAD, DST_NONE, SEQ_WAIT};
            6'd1:  u = uop(SRC_B0, SRC_B0, ACC_LOAD, DST_NONE);
            6'd2:  u = uop(SRC_B1, SRC_B1, ACC_ADD, DST_NONE);
            6'd3:  u = uop(SRC_B2, SRC_B2, ACC_ADD, DST_NONE);
            6'd4:  u = uop(SRC_B3, SRC_B3, ACC_ADD, DST_NONE);
            6'd5:  u = uop(SRC_KX, SRC_KX, ACC_ADD, DST_NONE);
            6'd6:  u = uop(SRC_KY, SRC_KY, ACC_ADD, DST_NONE);
            6'd7:  u = uop(SRC_KZ, SRC_KZ, ACC_ADD, DST_NORM);
            6'd10: u = uop(SRC_HALF, SRC_NORM, ACC_RSUB, DST_D0);
            6'd13: u = uop(SRC_KX, SRC_D0, ACC_LOAD, DST_D1);
            6'd14: u = uop(SRC_KY, SRC_D0, ACC_LOAD, DST_D2);
            6'd15: u = uop(SRC_KZ, SRC_D0, ACC_LOAD, DST_D3);
            6'd16: u = uop(SRC_B0, SRC_D0, ACC_LOAD, DST_NONE);
            6'd17: u = uop(SRC_B1, SRC_D1, ACC_SUB, DST_NONE);
            6'd18: u = uop(SRC_B2, SRC_D2, ACC_SUB, DST_NONE);
            6'd19: u = uop(SRC_B3, SRC_D3, ACC_SUB, DST_P0);
            6'd20: u = uop(SRC_B0, SRC_D1, ACC_LOAD, DST_NONE);
            6'd21: u = uop(SRC_B1, SRC_D0, ACC_ADD, DST_NONE);
            6'd22: u = uop(SRC_B2, SRC_D3, ACC_ADD, DST_NONE);
            6'd23: u = uop(SRC_B3, SRC_D2, ACC_SUB, DST_P1);
            6'd24: u = uop(SRC_B0, SRC_D2, ACC_LOAD, DST_NONE);
            6'd25: u = uop(SRC_B2, SRC_D0, ACC_ADD, DST_NONE);
            6'd26: u = uop(SRC_B3, SRC_D1, ACC_ADD, DST_NONE);
            6'd27: u = uop(SRC_B1, SRC_D3, ACC_SUB, DST_P2);
            6'd28: u = uop(SRC_B0, SRC_D3, ACC_LOAD, DST_NONE);
            6'd29: u = uop(SRC_B3, SRC_D0, ACC_ADD, DST_NONE);
            6'd30: u = uop(SRC_B1, SRC_D2, ACC_ADD, DST_NONE);
            6'd31: u = uop(SRC_B2, SRC_D1, ACC_SUB, DST_P3);
            6'd32: u = uop(SRC_P1, SRC_COS, ACC_LOAD, DST_NONE);
            6'd33: u = uop(SRC_P2, SRC_SIN, ACC_SUB, DST_B1);
            6'd34: u = uop(SRC_P2, SRC_COS, ACC_LOAD, DST_NONE);
            6'd35: u = uop(SRC_P1, SRC_SIN, ACC_ADD, DST_B2);
            6'd38: u = '{1'b0, SRC_B0, SRC_B0, ACC_LOAD, DST_NONE, SEQ_COMMIT};
            default: u = UC_NOP;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fixed_quaternion_attitude_update.sv -----
// Channel  Handshake            Payload
// cfg      cfg_we               cfg_index, cfg_data
// in       in_valid, in_stall   rate_roll, rate_yaw, rate_pitch
// out      out_valid, out_stall quat_w, quat_x, quat_y, quat_z
//
// An input is accepted only at the waiting step, so no new input is taken before the
// result commits: 31 products pass one shared two-stage multiplier, from issue through
// the s1 and s2 registers into the register that the operand mux reads.
// The next input is accepted once the result sits in the output register.
// A stalled result holds the sequencer at its last step.
// Reset loads the attitude with one and zeros and the rotation registers.
`default_nettype none

module fixed_quaternion_attitude_update (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  fqau_pkg::cfg_idx_t              cfg_index,
    input  logic [fqau_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [fqau_pkg::DATA_W-1:0] rate_roll,
    input  logic signed [fqau_pkg::DATA_W-1:0] rate_yaw,
    input  logic signed [fqau_pkg::DATA_W-1:0] rate_pitch,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [fqau_pkg::DATA_W-1:0] quat_w,
    output logic signed [fqau_pkg::DATA_W-1:0] quat_x,
    output logic signed [fqau_pkg::DATA_W-1:0] quat_y,
    output logic signed [fqau_pkg::DATA_W-1:0] quat_z
);
    import fqau_pkg::*;

    pc_t    pc_reg, pc_next;
    ucode_t uc;
    logic   in_fire, out_free, commit;

    logic [CFG_W-1:0]  cos_reg, sin_reg;
    logic [DATA_W-1:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic [DATA_W-1:0] kx_reg, ky_reg, kz_reg, norm_reg;
    logic [DATA_W-1:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic [DATA_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic [DATA_W-1:0] op_a, op_b, mag_a, mag_b;
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [DATA_W-1:0] ll_next, hl_next, lh_next, hh_next;

    logic              s1_valid_reg, s1_neg_reg;
    acc_op_t           s1_acc_reg;
    dst_t              s1_dst_reg;
    logic [DATA_W-1:0] s1_ll_reg, s1_hl_reg, s1_lh_reg, s1_hh_reg;

    logic [DATA_W-1:0] t_ll, t_hl, t_lh, r_sum, prod_next;
    logic              s2_valid_reg;
    acc_op_t           s2_acc_reg;
    dst_t              s2_dst_reg;
    logic [DATA_W-1:0] s2_prod_reg;

    assign uc       = ucode_rom(pc_reg);
    assign in_stall = (uc.seq != SEQ_WAIT);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (uc.seq == SEQ_COMMIT) && out_free;

    assign out_valid = out_valid_reg;
    assign quat_w    = qw_reg;
    assign quat_x    = qx_reg;
    assign quat_y    = qy_reg;
    assign quat_z    = qz_reg;

    always_comb
    begin
        case (uc.seq)
            SEQ_WAIT:   pc_next = in_fire ? pc_reg + PC_W'(1) : pc_reg;
            SEQ_NEXT:   pc_next = pc_reg + PC_W'(1);
            SEQ_COMMIT: pc_next = out_free ? '0 : pc_reg;
            default:    pc_next = '0;
        endcase
    end

    function automatic logic [DATA_W-1:0] pick(input src_t s,
        input logic [DATA_W-1:0] b0, input logic [DATA_W-1:0] b1,
        input logic [DATA_W-1:0] b2, input logic [DATA_W-1:0] b3,
        input logic [DATA_W-1:0] kx, input logic [DATA_W-1:0] ky,
        input logic [DATA_W-1:0] kz, input logic [DATA_W-1:0] d0,
        input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2,
        input logic [DATA_W-1:0] d3, input logic [DATA_W-1:0] p1,
        input logic [DATA_W-1:0] p2, input logic [DATA_W-1:0] nrm,
        input logic [CFG_W-1:0] rc, input logic [CFG_W-1:0] rs);
        logic [DATA_W-1:0] v;
        case (s)
            SRC_B0:   v = b0;
            SRC_B1:   v = b1;
            SRC_B2:   v = b2;
            SRC_B3:   v = b3;
            SRC_KX:   v = kx;
            SRC_KY:   v = ky;
            SRC_KZ:   v = kz;
            SRC_D0:   v = d0;
            SRC_D1:   v = d1;
            SRC_D2:   v = d2;
            SRC_D3:   v = d3;
            SRC_P1:   v = p1;
            SRC_P2:   v = p2;
            SRC_NORM: v = nrm;
            SRC_HALF: v = HALF_Q;
            SRC_COS:  v = DATA_W'(rc);
            SRC_SIN:  v = DATA_W'(rs);
            default:  v = '0;
        endcase
        return v;
    endfunction

    // issue: sign-magnitude split and partial products
    always_comb
    begin
        op_a = pick(uc.src_a, b0_reg, b1_reg, b2_reg, b3_reg, kx_reg, ky_reg, kz_reg,
                    d0_reg, d1_reg, d2_reg, d3_reg, p1_reg, p2_reg, norm_reg,
                    cos_reg, sin_reg);
        op_b = pick(uc.src_b, b0_reg, b1_reg, b2_reg, b3_reg, kx_reg, ky_reg, kz_reg,
                    d0_reg, d1_reg, d2_reg, d3_reg, p1_reg, p2_reg, norm_reg,
                    cos_reg, sin_reg);
        mag_a = op_a[DATA_W-1] ? ('0 - op_a) : op_a;
        mag_b = op_b[DATA_W-1] ? ('0 - op_b) : op_b;
        a_lo  = mag_a[HALF_W-1:0];
        a_hi  = mag_a[DATA_W-1:HALF_W];
        b_lo  = mag_b[HALF_W-1:0];
        b_hi  = mag_b[DATA_W-1:HALF_W];
        ll_next = a_lo * b_lo;
        hl_next = a_hi * b_lo;
        lh_next = b_hi * a_lo;
        hh_next = a_hi * b_hi;
    end

    // combine partial products with rounding, restore sign
    always_comb
    begin
        t_ll  = s1_ll_reg + RND_LO;
        t_hl  = s1_hl_reg + RND_MID;
        t_lh  = s1_lh_reg + RND_MID;
        r_sum = (t_ll >> FRAC_BITS) + (t_hl >> SHIFT_MID) + (t_lh >> SHIFT_MID)
              + (s1_hh_reg << SHIFT_HI);
        prod_next = s1_neg_reg ? ('0 - r_sum) : r_sum;
    end

    always_comb
    begin
        case (s2_acc_reg)
            ACC_LOAD: acc_next = s2_prod_reg;
            ACC_ADD:  acc_next = acc_reg + s2_prod_reg;
            ACC_SUB:  acc_next = acc_reg - s2_prod_reg;
            ACC_RSUB: acc_next = THREE_HALF_Q - s2_prod_reg;
            default:  acc_next = s2_prod_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cos_reg       <= ROT_COS_RESET;
            sin_reg       <= ROT_SIN_RESET;
            b0_reg        <= ONE_Q;
            b1_reg        <= '0;
            b2_reg        <= '0;
            b3_reg        <= '0;
        end
        else
        begin
            pc_reg       <= pc_next;
            s1_valid_reg <= uc.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_we && cfg_index == CFG_ROT_COS)
                cos_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_ROT_SIN)
                sin_reg <= cfg_data;
            if (s2_valid_reg && s2_dst_reg == DST_B1)
                b1_reg <= acc_next;
            if (s2_valid_reg && s2_dst_reg == DST_B2)
                b2_reg <= acc_next;
            if (commit)
            begin
                b0_reg        <= p0_reg;
                b3_reg        <= p3_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kx_reg <= rate_roll;
            ky_reg <= rate_yaw;
            kz_reg <= rate_pitch;
        end
        s1_neg_reg  <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
        s1_acc_reg  <= uc.acc;
        s1_dst_reg  <= uc.dst;
        s1_ll_reg   <= ll_next;
        s1_hl_reg   <= hl_next;
        s1_lh_reg   <= lh_next;
        s1_hh_reg   <= hh_next;
        s2_acc_reg  <= s1_acc_reg;
        s2_dst_reg  <= s1_dst_reg;
        s2_prod_reg <= prod_next;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
            case (s2_dst_reg)
                DST_NORM: norm_reg <= acc_next;
                DST_D0:   d0_reg   <= acc_next;
                DST_D1:   d1_reg   <= acc_next;
                DST_D2:   d2_reg   <= acc_next;
                DST_D3:   d3_reg   <= acc_next;
                DST_P0:   p0_reg   <= acc_next;
                DST_P1:   p1_reg   <= acc_next;
                DST_P2:   p2_reg   <= acc_next;
                DST_P3:   p3_reg   <= acc_next;
                default:  ;
            endcase
        end
        if (commit)
        begin
            qw_reg <= p0_reg;
            qx_reg <= b1_reg;
            qy_reg <= b2_reg;
            qz_reg <= p3_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fqau_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module fqau_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [fqau_pkg::DATA_W-1:0]  quat_w,
    input logic [fqau_pkg::DATA_W-1:0]  quat_x
);

    // busy right after an accepted transaction
    `ASSERT_NEXT(busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // no result appears the cycle after an accept
    `ASSERT_NEXT(no_instant_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

    // a fresh result frees the input side
    `ASSERT_NOW(ready_on_result, clk, rst_n, $rose(out_valid), !in_stall)

    // hold a stalled result
    `ASSERT_NEXT(hold_result, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(quat_w) && $stable(quat_x))

endmodule

bind fixed_quaternion_attitude_update fqau_checker u_fqau_checker (.*);

`default_nettype wire
